// ----- hdl/u8st_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_pkg
// Types, constants and the reverse character table shared by the UTF-8 to
// ST character set decoder and its checker.
// ----------------------------------------------------------------------------
package u8st_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] st_byte;
    logic       run_end;
  } out_item_t;

  localparam logic [7:0]  CHR_QMARK = 8'h3F;
  localparam logic [7:0]  CHR_CR    = 8'h0D;
  localparam logic [7:0]  CHR_LF    = 8'h0A;
  localparam logic [7:0]  CHR_TAB   = 8'h09;
  localparam logic [7:0]  CHR_DEL   = 8'h7F;
  localparam logic [7:0]  CHR_SPACE = 8'h20;

  localparam logic [20:0] CP_BOM       = 21'h00FEFF;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_MIN_LEN2  = 21'h000080;
  localparam logic [20:0] CP_MIN_LEN3  = 21'h000800;
  localparam logic [20:0] CP_MIN_LEN4  = 21'h010000;

  localparam logic [2:0]  SEQ_LEN2 = 3'd2;
  localparam logic [2:0]  SEQ_LEN3 = 3'd3;
  localparam logic [2:0]  SEQ_LEN4 = 3'd4;

  localparam int UPPER_N = 129;

  // code point of each ST byte from 0x7F upward
  localparam logic [15:0] UPPER_MAP [UPPER_N] = '{
    16'h0394,
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h00DF, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h00E3, 16'h00F5, 16'h00D8, 16'h00F8, 16'h0153, 16'h0152, 16'h00C0, 16'h00C3,
    16'h00D5, 16'h00A8, 16'h00B4, 16'h2020, 16'h00B6, 16'h00A9, 16'h00AE, 16'h2122,
    16'h0133, 16'h0132, 16'h05D0, 16'h05D1, 16'h05D2, 16'h05D3, 16'h05D4, 16'h05D5,
    16'h05D6, 16'h05D7, 16'h05D8, 16'h05D9, 16'h05DB, 16'h05DC, 16'h05DE, 16'h05E0,
    16'h05E1, 16'h05E2, 16'h05E4, 16'h05E6, 16'h05E7, 16'h05E8, 16'h05E9, 16'h05EA,
    16'h05DF, 16'h05DA, 16'h05DD, 16'h05E3, 16'h05E5, 16'h00A7, 16'h2227, 16'h221E,
    16'h03B1, 16'h03B2, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h2205, 16'h03C6, 16'h2208, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h00B3, 16'h00AF
  };

  // parallel compare against the table, lowest index wins; {hit, st byte}
  function automatic logic [8:0] st_lookup(logic [20:0] cp);
    logic [8:0] res;
    res = '0;
    for (int k = UPPER_N - 1; k >= 0; k--) begin
      if (cp == {5'b0, UPPER_MAP[k]}) begin
        res = {1'b1, 8'(k + 127)};
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/utf8_to_st_charset_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_st_charset_decoder
// Decodes a UTF-8 byte stream into ST character set bytes, replacing
// malformed input by '?', dropping a leading BOM and expanding LF to CR LF.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o   | in_item_i  (in_byte, is_final)
// out     | output    | out_valid_o / out_stall_i | out_item_o (st_byte, run_end)
//
// An input transaction passes the input register, then decode loads the result
// burst. One byte per cycle is sustained while each byte gives at most one
// result and the output is not stalled; a byte giving more than one result
// holds the input while the burst drains.
// Reset clears the open sequence and the burst, and starts a new text.
// out_stall_i only holds the burst; in_stall_o rises when decode can not load.
// ----------------------------------------------------------------------------
module utf8_to_st_charset_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8st_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8st_pkg::out_item_t out_item_o
);

  // input register
  logic               in_vld_q;
  u8st_pkg::in_item_t in_q;

  // decoder state
  logic [20:0] pv_q, pv_d;
  logic [2:0]  exp_q, exp_d;
  logic [1:0]  bh_q, bh_d;
  logic        ats_q, ats_d;
  logic        lwc_q, lwc_d;

  // result burst: pre '?'s, up to two bytes, post '?'s
  logic [2:0] pre_q, pre_d;
  logic [1:0] cpn_q, cpn_d;
  logic [7:0] c0_q, c0_d;
  logic [7:0] c1_q, c1_d;
  logic [1:0] post_q, post_d;
  logic [2:0] total;

  logic advance;
  logic take;

  assign total       = pre_q + {1'b0, cpn_q} + {1'b0, post_q};
  assign out_valid_o = (total != 3'd0);
  assign take        = out_valid_o && !out_stall_i;
  assign advance     = in_vld_q && ((total == 3'd0) || ((total == 3'd1) && !out_stall_i));
  assign in_stall_o  = in_vld_q && !advance;

  assign out_item_o.st_byte = (pre_q != 3'd0) ? u8st_pkg::CHR_QMARK :
                              (cpn_q != 2'd0) ? c0_q : u8st_pkg::CHR_QMARK;
  assign out_item_o.run_end = (total == 3'd1);

  // decode
  logic [7:0]  b;
  logic        cont;
  logic [20:0] pv_shift;
  logic [2:0]  held_inc;
  logic [20:0] least;
  logic        lead_go;
  logic        cp_go;
  logic [20:0] cp;
  logic        first;
  logic        lwc_eff;
  logic [8:0]  lk;

  assign b        = in_q.in_byte;
  assign cont     = (b[7:6] == 2'b10);
  assign pv_shift = {pv_q[14:0], b[5:0]};
  assign held_inc = {1'b0, bh_q} + 3'd1;
  assign least    = (exp_q == u8st_pkg::SEQ_LEN2) ? u8st_pkg::CP_MIN_LEN2 :
                    (exp_q == u8st_pkg::SEQ_LEN3) ? u8st_pkg::CP_MIN_LEN3 :
                                                   u8st_pkg::CP_MIN_LEN4;
  assign lk       = u8st_pkg::st_lookup(cp);

  always_comb begin
    pre_d   = 3'd0;
    cp_go   = 1'b0;
    cp      = '0;
    pv_d    = pv_q;
    exp_d   = exp_q;
    bh_d    = bh_q;
    lead_go = 1'b0;
    cpn_d   = 2'd0;
    c0_d    = u8st_pkg::CHR_QMARK;
    c1_d    = u8st_pkg::CHR_QMARK;
    post_d  = 2'd0;

    if (exp_q != 3'd0) begin
      if (cont) begin
        if (held_inc >= exp_q) begin
          pv_d  = '0;
          exp_d = 3'd0;
          bh_d  = 2'd0;
          if (pv_shift < least || pv_shift > u8st_pkg::CP_MAX ||
              (pv_shift >= u8st_pkg::CP_SURR_LO && pv_shift <= u8st_pkg::CP_SURR_HI)) begin
            pre_d = exp_q;
          end else begin
            cp_go = 1'b1;
            cp    = pv_shift;
          end
        end else begin
          pv_d = pv_shift;
          bh_d = held_inc[1:0];
        end
      end else begin
        // broken sequence: flush held bytes, then treat this byte as a lead
        pre_d   = {1'b0, bh_q};
        pv_d    = '0;
        exp_d   = 3'd0;
        bh_d    = 2'd0;
        lead_go = 1'b1;
      end
    end else begin
      lead_go = 1'b1;
    end

    if (lead_go) begin
      priority if (!b[7]) begin
        cp_go = 1'b1;
        cp    = {13'b0, b};
      end else if (b[7:5] == 3'b110) begin
        pv_d  = {16'b0, b[4:0]};
        exp_d = u8st_pkg::SEQ_LEN2;
        bh_d  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        pv_d  = {17'b0, b[3:0]};
        exp_d = u8st_pkg::SEQ_LEN3;
        bh_d  = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        pv_d  = {18'b0, b[2:0]};
        exp_d = u8st_pkg::SEQ_LEN4;
        bh_d  = 2'd1;
      end else begin
        pre_d = pre_d + 3'd1;
      end
    end

    // any '?' before the code point ends the text start and clears the CR mark
    first   = ats_q && (pre_d == 3'd0);
    lwc_eff = lwc_q && (pre_d == 3'd0);

    if (cp_go) begin
      priority if (first && cp == u8st_pkg::CP_BOM) begin
        cpn_d = 2'd0;
      end else if (cp == {13'b0, u8st_pkg::CHR_LF}) begin
        if (!lwc_eff) begin
          cpn_d = 2'd2;
          c0_d  = u8st_pkg::CHR_CR;
          c1_d  = u8st_pkg::CHR_LF;
        end else begin
          cpn_d = 2'd1;
          c0_d  = u8st_pkg::CHR_LF;
        end
      end else if (cp == {13'b0, u8st_pkg::CHR_CR} || cp == {13'b0, u8st_pkg::CHR_TAB}) begin
        cpn_d = 2'd1;
        c0_d  = cp[7:0];
      end else if (cp < {13'b0, u8st_pkg::CHR_SPACE} || cp == {13'b0, u8st_pkg::CHR_DEL}) begin
        cpn_d = 2'd0;
      end else if (cp < {13'b0, u8st_pkg::CHR_DEL}) begin
        cpn_d = 2'd1;
        c0_d  = cp[7:0];
      end else begin
        cpn_d = 2'd1;
        c0_d  = lk[8] ? lk[7:0] : u8st_pkg::CHR_QMARK;
      end
    end

    ats_d = ats_q && (pre_d == 3'd0) && !cp_go;
    if (cpn_d == 2'd2) begin
      lwc_d = (c1_d == u8st_pkg::CHR_CR);
    end else if (cpn_d == 2'd1) begin
      lwc_d = (c0_d == u8st_pkg::CHR_CR);
    end else if (pre_d != 3'd0) begin
      lwc_d = 1'b0;
    end else begin
      lwc_d = lwc_q;
    end

    if (in_q.is_final) begin
      // truncated sequence at end of text
      if (exp_d != 3'd0) begin
        post_d = bh_d;
      end
      pv_d  = '0;
      exp_d = 3'd0;
      bh_d  = 2'd0;
      ats_d = 1'b1;
      lwc_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      exp_q <= 3'd0;
      bh_q  <= 2'd0;
      ats_q <= 1'b1;
      lwc_q <= 1'b0;
    end else if (advance) begin
      pv_q  <= pv_d;
      exp_q <= exp_d;
      bh_q  <= bh_d;
      ats_q <= ats_d;
      lwc_q <= lwc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= 3'd0;
      cpn_q  <= 2'd0;
      post_q <= 2'd0;
    end else if (advance) begin
      pre_q  <= pre_d;
      cpn_q  <= cpn_d;
      post_q <= post_d;
    end else if (take) begin
      if (pre_q != 3'd0) begin
        pre_q <= pre_q - 3'd1;
      end else if (cpn_q != 2'd0) begin
        cpn_q <= cpn_q - 2'd1;
      end else begin
        post_q <= post_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c0_q <= c0_d;
      c1_q <= c1_d;
    end else if (take && pre_q == 3'd0 && cpn_q != 2'd0) begin
      c0_q <= c1_q;
    end
  end

endmodule

// ----- hdl/u8st_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8st_checker
// Port-level checks for the UTF-8 to ST character set decoder.
// ----------------------------------------------------------------------------
module u8st_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input u8st_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input u8st_pkg::out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // a burst only ends on a transaction marked run_end
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.run_end |=> out_valid_o)
    else $error("result burst ended without run_end");

  // with no result pending the input is never held
  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output idle");

endmodule

bind utf8_to_st_charset_decoder u8st_checker u_u8st_checker (.*);

// ----- tb/sv/utf8_to_st_charset_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_st_charset_decoder_test
// Drives UTF-8 text into the decoder and compares every ST character it
// returns with a behavioral decoder kept alongside, under random idling on
// the input and backpressure on the output.
// ----------------------------------------------------------------------------
module utf8_to_st_charset_decoder_test;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  u8st_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  u8st_pkg::out_item_t out_item;

  utf8_to_st_charset_decoder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // decoder state as seen from the text
  logic [20:0] cp_acc     = '0;
  logic [2:0]  seq_len    = '0;
  logic [1:0]  seq_got    = '0;
  bit          text_start = 1'b1;
  bit          prev_cr    = 1'b0;

  u8st_pkg::out_item_t burst_q[$];
  u8st_pkg::out_item_t st_chars_q[$];
  logic [7:0]          tok_q[$];

  int err_cnt    = 0;
  int bytes_sent = 0;
  int chars_seen = 0;
  int texts_done = 0;
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  int hold_req   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("timeout with %0d characters still expected", st_chars_q.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------- behavioral decoder ----------------

  task automatic emit(logic [7:0] b);
    u8st_pkg::out_item_t r;
    r.st_byte = b;
    r.run_end = 1'b0;
    burst_q.push_back(r);
    prev_cr = (b == u8st_pkg::CHR_CR);
  endtask

  task automatic emit_bad(int n);
    for (int i = 0; i < n; i++) emit(u8st_pkg::CHR_QMARK);
    text_start = 1'b0;
  endtask

  task automatic drop_seq();
    cp_acc  = '0;
    seq_len = '0;
    seq_got = '0;
  endtask

  task automatic map_cp(logic [20:0] cp);
    bit first;
    first = text_start;
    text_start = 1'b0;
    if (first && cp == u8st_pkg::CP_BOM) return;
    if (cp == u8st_pkg::CHR_LF) begin
      if (!prev_cr) emit(u8st_pkg::CHR_CR);
      emit(u8st_pkg::CHR_LF);
      return;
    end
    if (cp == u8st_pkg::CHR_CR || cp == u8st_pkg::CHR_TAB) begin
      emit(cp[7:0]);
      return;
    end
    if (cp < u8st_pkg::CHR_SPACE || cp == u8st_pkg::CHR_DEL) return;
    if (cp < u8st_pkg::CHR_DEL) begin
      emit(cp[7:0]);
      return;
    end
    for (int k = 0; k < u8st_pkg::UPPER_N; k++) begin
      if (cp == {5'b0, u8st_pkg::UPPER_MAP[k]}) begin
        emit(u8st_pkg::CHR_DEL + 8'(k));
        return;
      end
    end
    emit(u8st_pkg::CHR_QMARK);
  endtask

  task automatic take_lead(logic [7:0] b);
    if (b < 8'h80) begin
      map_cp({13'b0, b});
    end else if (b[7:5] == 3'b110) begin
      cp_acc = {16'b0, b[4:0]}; seq_len = u8st_pkg::SEQ_LEN2; seq_got = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = {17'b0, b[3:0]}; seq_len = u8st_pkg::SEQ_LEN3; seq_got = 2'd1;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = {18'b0, b[2:0]}; seq_len = u8st_pkg::SEQ_LEN4; seq_got = 2'd1;
    end else begin
      emit_bad(1);
    end
  endtask

  task automatic decode_step(input u8st_pkg::in_item_t it);
    int                  held;
    int                  len;
    logic [20:0]         v;
    logic [20:0]         least;
    u8st_pkg::out_item_t r;
    burst_q.delete();
    if (seq_len != 0) begin
      if (it.in_byte[7:6] == 2'b10) begin
        held = seq_got + 1;
        cp_acc = {cp_acc[14:0], it.in_byte[5:0]};
        if (held >= seq_len) begin
          v = cp_acc;
          len = seq_len;
          least = (seq_len == u8st_pkg::SEQ_LEN2) ? u8st_pkg::CP_MIN_LEN2 :
                  (seq_len == u8st_pkg::SEQ_LEN3) ? u8st_pkg::CP_MIN_LEN3 :
                                                    u8st_pkg::CP_MIN_LEN4;
          drop_seq();
          if (v < least || v > u8st_pkg::CP_MAX ||
              (v >= u8st_pkg::CP_SURR_LO && v <= u8st_pkg::CP_SURR_HI)) begin
            emit_bad(len);
          end else begin
            map_cp(v);
          end
        end else begin
          seq_got = 2'(held);
        end
      end else begin
        held = seq_got;
        drop_seq();
        emit_bad(held);
        take_lead(it.in_byte);
      end
    end else begin
      take_lead(it.in_byte);
    end
    if (it.is_final) begin
      // flush a truncated sequence and start a new text
      if (seq_len != 0) emit_bad(seq_got);
      drop_seq();
      text_start = 1'b1;
      prev_cr = 1'b0;
    end
    while (burst_q.size() > 0) begin
      r = burst_q.pop_front();
      r.run_end = (burst_q.size() == 0);
      st_chars_q.push_back(r);
    end
  endtask

  // ---------------- channels ----------------

  task automatic send_byte(logic [7:0] b, bit fin);
    u8st_pkg::in_item_t it;
    int                 gap;
    it.in_byte  = b;
    it.is_final = fin;
    if (!gaps_on) begin
      gap = 0;
    end else if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_step(it);
    bytes_sent++;
    if (fin) texts_done++;
  endtask

  task automatic send_text(logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (st_chars_q.size() != 0) @(posedge clk);
  endtask

  // receiver stalls on segments of its own, with an occasional long hold-off
  initial begin : receiver
    int seg_kind;
    int seg_len;
    int hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      seg_kind = $urandom_range(0, 3);
      seg_len  = $urandom_range(4, 40);
      for (int c = 0; c < seg_len; c++) begin
        @(negedge clk);
        if (hold_left == 0 && hold_req > 0) begin
          hold_left = hold_req;
          hold_req  = 0;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          case (seg_kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= c[0];
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    u8st_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      chars_seen++;
      if (st_chars_q.size() == 0) begin
        $error("unexpected transaction: st_byte %h run_end %b",
               out_item.st_byte, out_item.run_end);
        err_cnt++;
      end else begin
        want = st_chars_q.pop_front();
        if (out_item.st_byte !== want.st_byte) begin
          $error("st_byte: expected %h, actual %h", want.st_byte, out_item.st_byte);
          err_cnt++;
        end
        if (out_item.run_end !== want.run_end) begin
          $error("run_end: expected %b, actual %b", want.run_end, out_item.run_end);
          err_cnt++;
        end
      end
    end
  end

  // ---------------- text generation ----------------

  function automatic void put_seq(logic [20:0] cp, int len);
    case (len)
      1: tok_q.push_back(cp[7:0]);
      2: begin
        tok_q.push_back({3'b110, cp[10:6]});
        tok_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        tok_q.push_back({4'b1110, cp[15:12]});
        tok_q.push_back({2'b10, cp[11:6]});
        tok_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        tok_q.push_back({5'b11110, cp[20:18]});
        tok_q.push_back({2'b10, cp[17:12]});
        tok_q.push_back({2'b10, cp[11:6]});
        tok_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void put_cp(logic [20:0] cp);
    put_seq(cp, cp < u8st_pkg::CP_MIN_LEN2 ? 1 :
                cp < u8st_pkg::CP_MIN_LEN3 ? 2 :
                cp < u8st_pkg::CP_MIN_LEN4 ? 3 : 4);
  endfunction

  function automatic logic [20:0] rand_cp(int len);
    case (len)
      2:       return 21'($urandom_range(32'h80, 32'h7FF));
      3:       return 21'($urandom_range(32'h800, 32'hFFFF));
      default: return 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
  endfunction

  task automatic make_token();
    int          kind;
    int          len;
    logic [20:0] cp;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      tok_q.push_back(8'($urandom_range(32, 126)));
    end else if (kind < 45) begin
      put_cp({5'b0, u8st_pkg::UPPER_MAP[$urandom_range(0, u8st_pkg::UPPER_N - 1)]});
    end else if (kind < 52) begin
      case ($urandom_range(0, 4))
        0: tok_q.push_back(u8st_pkg::CHR_LF);
        1: tok_q.push_back(u8st_pkg::CHR_CR);
        2: tok_q.push_back(u8st_pkg::CHR_TAB);
        3: begin
          tok_q.push_back(u8st_pkg::CHR_CR);
          tok_q.push_back(u8st_pkg::CHR_LF);
        end
        default: tok_q.push_back($urandom_range(0, 1) ? u8st_pkg::CHR_DEL :
                                                        8'($urandom_range(0, 31)));
      endcase
    end else if (kind < 60) begin
      put_cp(rand_cp($urandom_range(2, 4)));
    end else if (kind < 64) begin
      put_cp(u8st_pkg::CP_BOM);
    end else if (kind < 70) begin
      // overlong: value below the minimum for its length
      len = $urandom_range(2, 4);
      cp = (len == 2) ? 21'($urandom_range(0, 32'h7F)) :
           (len == 3) ? 21'($urandom_range(0, 32'h7FF)) : 21'($urandom_range(0, 32'hFFFF));
      put_seq(cp, len);
    end else if (kind < 74) begin
      put_cp(u8st_pkg::CP_SURR_LO + 21'($urandom_range(0, 32'h7FF)));
    end else if (kind < 78) begin
      put_seq(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
    end else if (kind < 86) begin
      // truncated sequence, the next token breaks in
      len = $urandom_range(2, 4);
      put_seq(rand_cp(len), len);
      repeat ($urandom_range(1, len - 1)) void'(tok_q.pop_back());
    end else if (kind < 92) begin
      tok_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(32'h80, 32'hBF)) :
                                             8'($urandom_range(32'hF8, 32'hFF)));
    end else begin
      tok_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_bom();
    // dropped at text start, replaced when it comes second
    send_text('{8'hEF, 8'hBB, 8'hBF, 8'hEF, 8'hBB, 8'hBF});
  endtask

  task automatic test_ascii_controls();
    send_text('{u8st_pkg::CHR_LF, u8st_pkg::CHR_CR, u8st_pkg::CHR_LF,
                u8st_pkg::CHR_TAB, 8'h00, u8st_pkg::CHR_DEL});
  endtask

  task automatic test_multibyte();
    send_text('{8'hC3, 8'hA9, 8'hE2, 8'h88, 8'h9E});
  endtask

  task automatic test_malformed();
    // bad lead, overlong, surrogate, lead past the range broken by LF, truncation
    send_text('{8'hFF, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80,
                8'hF5, 8'h80, 8'h80, u8st_pkg::CHR_LF, 8'hC3});
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 80;
    for (int i = 0; i < 30; i++) begin
      send_byte((i % 5 == 4) ? u8st_pkg::CHR_LF : 8'(8'h61 + i), i == 29);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_byte(8'h48, 1'b0);
    send_byte(u8st_pkg::CHR_LF, 1'b0);
    stop_sending();
    wait_drained();
    send_byte(8'hCE, 1'b0);
    send_byte(8'hB1, 1'b1);
  endtask

  task automatic test_random_text();
    bit         fin;
    logic [7:0] b;
    while (bytes_sent < 108) begin
      make_token();
      fin = ($urandom_range(0, 9) == 0);
      while (tok_q.size() > 0) begin
        b = tok_q.pop_front();
        send_byte(b, fin && tok_q.size() == 0);
      end
      if ($urandom_range(0, 39) == 0) begin
        stop_sending();
        wait_drained();
      end
      if ($urandom_range(0, 29) == 0) gaps_on = !gaps_on;
    end
    send_byte(8'h2E, 1'b1);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_bom();
    test_ascii_controls();
    test_multibyte();
    test_malformed();
    test_backpressure();
    test_drain_pause();
    test_random_text();

    stop_sending();
    wait_drained();
    repeat (10) @(posedge clk);

    $display("sent %0d UTF-8 bytes in %0d texts, checked %0d ST characters",
             bytes_sent, texts_done, chars_seen);
    $display("covered BOM, LF expansion, controls, table lookups and malformed input");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
